[hw/rtl/rtt_pkg.sv]
// ---------------------------------------------------------------------------
// Rectangle tessellator package
// Shared types, register indexes and saturation helper.
// ---------------------------------------------------------------------------
package rtt_pkg;

   localparam int HALF_W  = 30;
   localparam int BIS_LAT = 70;

   localparam logic [2:0] CSR_XF_EN   = 3'd0;
   localparam logic [2:0] CSR_COEF_XX = 3'd1;
   localparam logic [2:0] CSR_COEF_XY = 3'd2;
   localparam logic [2:0] CSR_COEF_YX = 3'd3;
   localparam logic [2:0] CSR_COEF_YY = 3'd4;
   localparam logic [2:0] CSR_SHIFT_X = 3'd5;
   localparam logic [2:0] CSR_SHIFT_Y = 3'd6;

   localparam logic [1:0] CRN_TL = 2'd0;
   localparam logic [1:0] CRN_TR = 2'd1;
   localparam logic [1:0] CRN_BL = 2'd2;
   localparam logic [1:0] CRN_BR = 2'd3;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } pt_type;

   typedef pt_type [3:0] quad_type;

   typedef struct packed {
      logic              valid;
      logic              stroke;
      logic              xf_en;
      logic [HALF_W-1:0] half;
   } meta_type;

   typedef struct packed {
      pt_type a;
      pt_type b;
      pt_type c;
      logic   last;
   } tri_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[hw/rtl/rtt_xform.sv]
// ---------------------------------------------------------------------------
// Rectangle tessellator affine transform
// Maps the four corners through the 2x3 matrix when enabled, in two stages.
// ---------------------------------------------------------------------------
module rtt_xform #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  rtt_pkg::meta_type   meta_in,
   input  logic signed [31:0]  left,
   input  logic signed [31:0]  top,
   input  logic signed [31:0]  right,
   input  logic signed [31:0]  bottom,
   input  logic signed [31:0]  coef_xx,
   input  logic signed [31:0]  coef_xy,
   input  logic signed [31:0]  coef_yx,
   input  logic signed [31:0]  coef_yy,
   input  logic signed [31:0]  shift_x,
   input  logic signed [31:0]  shift_y,
   output rtt_pkg::meta_type   meta_out,
   output rtt_pkg::quad_type   quad_out
);

   rtt_pkg::meta_type  meta1_ff, meta2_ff;
   logic signed [63:0] pxl_ff, pxr_ff, pyxt_ff, pyxb_ff;
   logic signed [63:0] pxyl_ff, pxyr_ff, pyyt_ff, pyyb_ff;
   logic signed [31:0] l_ff, t_ff, r_ff, b_ff;
   logic signed [31:0] sx_ff, sy_ff;
   rtt_pkg::quad_type  quad_in, quad_ff;

   function automatic logic signed [65:0] rnd(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = (p + (64'sd1 <<< (COORD_FRAC_BITS - 1))) >>> COORD_FRAC_BITS;
      return 66'(s);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         meta1_ff <= '0;
         meta2_ff <= '0;
      end else begin
         meta1_ff <= meta_in;
         meta2_ff <= meta1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pxl_ff  <= 64'(coef_xx) * 64'(left);
      pxr_ff  <= 64'(coef_xx) * 64'(right);
      pyxt_ff <= 64'(coef_yx) * 64'(top);
      pyxb_ff <= 64'(coef_yx) * 64'(bottom);
      pxyl_ff <= 64'(coef_xy) * 64'(left);
      pxyr_ff <= 64'(coef_xy) * 64'(right);
      pyyt_ff <= 64'(coef_yy) * 64'(top);
      pyyb_ff <= 64'(coef_yy) * 64'(bottom);
      l_ff    <= left;
      t_ff    <= top;
      r_ff    <= right;
      b_ff    <= bottom;
      sx_ff   <= shift_x;
      sy_ff   <= shift_y;
      quad_ff <= quad_in;
   end

   always_comb begin
      if (meta1_ff.xf_en) begin
         quad_in[rtt_pkg::CRN_TL].x = rtt_pkg::sat32(rnd(pxl_ff) + rnd(pyxt_ff) + 66'(sx_ff));
         quad_in[rtt_pkg::CRN_TL].y = rtt_pkg::sat32(rnd(pxyl_ff) + rnd(pyyt_ff) + 66'(sy_ff));
         quad_in[rtt_pkg::CRN_TR].x = rtt_pkg::sat32(rnd(pxr_ff) + rnd(pyxt_ff) + 66'(sx_ff));
         quad_in[rtt_pkg::CRN_TR].y = rtt_pkg::sat32(rnd(pxyr_ff) + rnd(pyyt_ff) + 66'(sy_ff));
         quad_in[rtt_pkg::CRN_BL].x = rtt_pkg::sat32(rnd(pxl_ff) + rnd(pyxb_ff) + 66'(sx_ff));
         quad_in[rtt_pkg::CRN_BL].y = rtt_pkg::sat32(rnd(pxyl_ff) + rnd(pyyb_ff) + 66'(sy_ff));
         quad_in[rtt_pkg::CRN_BR].x = rtt_pkg::sat32(rnd(pxr_ff) + rnd(pyxb_ff) + 66'(sx_ff));
         quad_in[rtt_pkg::CRN_BR].y = rtt_pkg::sat32(rnd(pxyr_ff) + rnd(pyyb_ff) + 66'(sy_ff));
      end else begin
         quad_in[rtt_pkg::CRN_TL].x = l_ff;
         quad_in[rtt_pkg::CRN_TL].y = t_ff;
         quad_in[rtt_pkg::CRN_TR].x = r_ff;
         quad_in[rtt_pkg::CRN_TR].y = t_ff;
         quad_in[rtt_pkg::CRN_BL].x = l_ff;
         quad_in[rtt_pkg::CRN_BL].y = b_ff;
         quad_in[rtt_pkg::CRN_BR].x = r_ff;
         quad_in[rtt_pkg::CRN_BR].y = b_ff;
      end
   end

   assign meta_out = meta2_ff;
   assign quad_out = quad_ff;

endmodule

[hw/rtl/rtt_bisect.sv]
// ---------------------------------------------------------------------------
// Rectangle tessellator corner bisector offset
// Normalises the corner bisector, takes its length by a pipelined square
// root and scales it to half the stroke width by a pipelined divider.
// ---------------------------------------------------------------------------
module rtt_bisect (
   input  logic                          clock,
   input  rtt_pkg::pt_type               corner,
   input  rtt_pkg::pt_type               side_a,
   input  rtt_pkg::pt_type               side_b,
   input  logic [rtt_pkg::HALF_W-1:0]    half,
   output rtt_pkg::pt_type               offset
);

   localparam int SQ_N = 32;
   localparam int DV_N = rtt_pkg::HALF_W;

   typedef struct packed {
      logic                       sx;
      logic                       sy;
      logic                       zero;
      logic [30:0]                ax;
      logic [30:0]                ay;
      logic [rtt_pkg::HALF_W-1:0] h;
   } side_type;

   logic signed [34:0] vx_in, vy_in;
   logic [33:0]        ax1_ff, ay1_ff, ax2_ff, ay2_ff, m1;
   logic               sx1_ff, sy1_ff, sx2_ff, sy2_ff;
   logic               zero2_ff;
   logic [rtt_pkg::HALF_W-1:0] h1_ff, h2_ff;
   logic [5:0]         pos_in, pos_ff;
   side_type           s3_ff, s4_ff, side_m_ff;
   logic [61:0]        sqx_ff, sqy_ff;
   logic [63:0]        sq_n_ff [SQ_N+1];
   logic [63:0]        sq_r_ff [SQ_N+1];
   side_type           sq_s_ff [SQ_N+1];
   logic [31:0]        len_ff;
   logic [60:0]        mx_ff, my_ff;
   logic [62:0]        dv_rx_ff [DV_N+1];
   logic [62:0]        dv_ry_ff [DV_N+1];
   logic [32:0]        dv_d_ff  [DV_N+1];
   logic [DV_N-1:0]    dv_qx_ff [DV_N+1];
   logic [DV_N-1:0]    dv_qy_ff [DV_N+1];
   side_type           dv_s_ff  [DV_N+1];
   rtt_pkg::pt_type    off_ff;

   assign vx_in = (35'(corner.x) <<< 1) - 35'(side_a.x) - 35'(side_b.x);
   assign vy_in = (35'(corner.y) <<< 1) - 35'(side_a.y) - 35'(side_b.y);

   always_ff @(posedge clock) begin
      sx1_ff <= vx_in[34];
      sy1_ff <= vy_in[34];
      ax1_ff <= vx_in[34] ? 34'(-vx_in) : 34'(vx_in);
      ay1_ff <= vy_in[34] ? 34'(-vy_in) : 34'(vy_in);
      h1_ff  <= half;
   end

   assign m1 = (ax1_ff > ay1_ff) ? ax1_ff : ay1_ff;

   always_comb begin
      pos_in = '0;
      for (int i = 0; i < 34; i++) begin
         if (m1[i]) begin
            pos_in = 6'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      ax2_ff   <= ax1_ff;
      ay2_ff   <= ay1_ff;
      sx2_ff   <= sx1_ff;
      sy2_ff   <= sy1_ff;
      h2_ff    <= h1_ff;
      pos_ff   <= pos_in;
      zero2_ff <= (m1 == '0);
   end

   // Bring the larger magnitude to bit 30 by shifting both together.
   always_ff @(posedge clock) begin
      s3_ff.sx   <= sx2_ff;
      s3_ff.sy   <= sy2_ff;
      s3_ff.zero <= zero2_ff;
      s3_ff.h    <= h2_ff;
      if (pos_ff > 6'd30) begin
         s3_ff.ax <= 31'(ax2_ff >> (pos_ff - 6'd30));
         s3_ff.ay <= 31'(ay2_ff >> (pos_ff - 6'd30));
      end else begin
         s3_ff.ax <= 31'(ax2_ff << (6'd30 - pos_ff));
         s3_ff.ay <= 31'(ay2_ff << (6'd30 - pos_ff));
      end
   end

   always_ff @(posedge clock) begin
      sqx_ff <= 62'(s3_ff.ax) * 62'(s3_ff.ax);
      sqy_ff <= 62'(s3_ff.ay) * 62'(s3_ff.ay);
      s4_ff  <= s3_ff;
      sq_n_ff[0] <= 64'(sqx_ff) + 64'(sqy_ff);
      sq_r_ff[0] <= '0;
      sq_s_ff[0] <= s4_ff;
   end

   // One result bit of the integer square root per stage.
   for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] trial;
      logic        take;
      assign trial = sq_r_ff[k] + BIT;
      assign take  = (sq_n_ff[k] >= trial);
      always_ff @(posedge clock) begin
         sq_n_ff[k+1] <= take ? (sq_n_ff[k] - trial) : sq_n_ff[k];
         sq_r_ff[k+1] <= take ? ((sq_r_ff[k] >> 1) + BIT) : (sq_r_ff[k] >> 1);
         sq_s_ff[k+1] <= sq_s_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= sq_r_ff[SQ_N][31:0];
      mx_ff     <= 61'(sq_s_ff[SQ_N].ax) * 61'(sq_s_ff[SQ_N].h);
      my_ff     <= 61'(sq_s_ff[SQ_N].ay) * 61'(sq_s_ff[SQ_N].h);
      side_m_ff <= sq_s_ff[SQ_N];
      dv_rx_ff[0] <= {1'b0, mx_ff, 1'b0} + 63'(len_ff);
      dv_ry_ff[0] <= {1'b0, my_ff, 1'b0} + 63'(len_ff);
      dv_d_ff[0]  <= {len_ff, 1'b0};
      dv_qx_ff[0] <= '0;
      dv_qy_ff[0] <= '0;
      dv_s_ff[0]  <= side_m_ff;
   end

   // Restoring division, one quotient bit per stage; the quotient never
   // exceeds half the stroke width, so it fits in HALF_W bits.
   for (genvar i = 0; i < DV_N; i++) begin : g_div
      logic [62:0] dsh;
      logic        tx, ty;
      assign dsh = 63'(dv_d_ff[i]) << (DV_N - 1 - i);
      assign tx  = (dv_rx_ff[i] >= dsh);
      assign ty  = (dv_ry_ff[i] >= dsh);
      always_ff @(posedge clock) begin
         dv_rx_ff[i+1] <= tx ? (dv_rx_ff[i] - dsh) : dv_rx_ff[i];
         dv_ry_ff[i+1] <= ty ? (dv_ry_ff[i] - dsh) : dv_ry_ff[i];
         dv_qx_ff[i+1] <= {dv_qx_ff[i][DV_N-2:0], tx};
         dv_qy_ff[i+1] <= {dv_qy_ff[i][DV_N-2:0], ty};
         dv_d_ff[i+1]  <= dv_d_ff[i];
         dv_s_ff[i+1]  <= dv_s_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (dv_s_ff[DV_N].zero) begin
         off_ff <= '0;
      end else begin
         off_ff.x <= dv_s_ff[DV_N].sx ? -32'(dv_qx_ff[DV_N]) : 32'(dv_qx_ff[DV_N]);
         off_ff.y <= dv_s_ff[DV_N].sy ? -32'(dv_qy_ff[DV_N]) : 32'(dv_qy_ff[DV_N]);
      end
   end

   assign offset = off_ff;

endmodule

[hw/rtl/rtt_emit.sv]
// ---------------------------------------------------------------------------
// Rectangle tessellator triangle emitter
// Holds one outline and sends out its triangles, one beat per cycle.
// ---------------------------------------------------------------------------
module rtt_emit (
   input  logic                clock,
   input  logic                reset,
   input  rtt_pkg::meta_type   meta_in,
   input  rtt_pkg::quad_type   outer,
   input  rtt_pkg::quad_type   inner,
   output logic                tri_valid,
   output rtt_pkg::tri_type    tri_out
);

   logic              act_ff, act_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              stroke_ff;
   rtt_pkg::quad_type o_ff, i_ff;
   logic [2:0]        last_idx;
   rtt_pkg::tri_type  tri_in, tri_ff;
   logic              valid_ff;

   assign last_idx = stroke_ff ? 3'd7 : 3'd1;

   always_comb begin
      act_in = act_ff;
      cnt_in = cnt_ff;
      if (meta_in.valid) begin
         act_in = 1'b1;
         cnt_in = '0;
      end else if (act_ff) begin
         if (cnt_ff == last_idx) begin
            act_in = 1'b0;
         end
         cnt_in = cnt_ff + 3'd1;
      end
   end

   always_comb begin
      tri_in.last = (cnt_ff == last_idx);
      tri_in.a    = o_ff[rtt_pkg::CRN_TL];
      tri_in.b    = o_ff[rtt_pkg::CRN_TR];
      tri_in.c    = o_ff[rtt_pkg::CRN_BL];
      case ({stroke_ff, cnt_ff})
         4'b0_000: begin
            tri_in.a = o_ff[rtt_pkg::CRN_TL];
            tri_in.b = o_ff[rtt_pkg::CRN_TR];
            tri_in.c = o_ff[rtt_pkg::CRN_BL];
         end
         4'b0_001: begin
            tri_in.a = o_ff[rtt_pkg::CRN_BL];
            tri_in.b = o_ff[rtt_pkg::CRN_TR];
            tri_in.c = o_ff[rtt_pkg::CRN_BR];
         end
         4'b1_000: begin
            tri_in.a = o_ff[rtt_pkg::CRN_TL];
            tri_in.b = o_ff[rtt_pkg::CRN_TR];
            tri_in.c = i_ff[rtt_pkg::CRN_TL];
         end
         4'b1_001: begin
            tri_in.a = i_ff[rtt_pkg::CRN_TL];
            tri_in.b = o_ff[rtt_pkg::CRN_TR];
            tri_in.c = i_ff[rtt_pkg::CRN_TR];
         end
         4'b1_010: begin
            tri_in.a = o_ff[rtt_pkg::CRN_TR];
            tri_in.b = o_ff[rtt_pkg::CRN_BR];
            tri_in.c = i_ff[rtt_pkg::CRN_TR];
         end
         4'b1_011: begin
            tri_in.a = i_ff[rtt_pkg::CRN_TR];
            tri_in.b = o_ff[rtt_pkg::CRN_BR];
            tri_in.c = i_ff[rtt_pkg::CRN_BR];
         end
         4'b1_100: begin
            tri_in.a = o_ff[rtt_pkg::CRN_BR];
            tri_in.b = o_ff[rtt_pkg::CRN_BL];
            tri_in.c = i_ff[rtt_pkg::CRN_BR];
         end
         4'b1_101: begin
            tri_in.a = i_ff[rtt_pkg::CRN_BR];
            tri_in.b = o_ff[rtt_pkg::CRN_BL];
            tri_in.c = i_ff[rtt_pkg::CRN_BL];
         end
         4'b1_110: begin
            tri_in.a = o_ff[rtt_pkg::CRN_BL];
            tri_in.b = o_ff[rtt_pkg::CRN_TL];
            tri_in.c = i_ff[rtt_pkg::CRN_BL];
         end
         4'b1_111: begin
            tri_in.a = i_ff[rtt_pkg::CRN_BL];
            tri_in.b = o_ff[rtt_pkg::CRN_TL];
            tri_in.c = i_ff[rtt_pkg::CRN_TL];
         end
         default: begin
            tri_in.last = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= 1'b0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         act_ff   <= act_in;
         cnt_ff   <= cnt_in;
         valid_ff <= act_ff;
      end
   end

   always_ff @(posedge clock) begin
      tri_ff <= tri_in;
      if (meta_in.valid) begin
         stroke_ff <= meta_in.stroke;
         o_ff      <= outer;
         i_ff      <= inner;
      end
   end

   assign tri_valid = valid_ff;
   assign tri_out   = tri_ff;

endmodule

[hw/rtl/rectangle_triangle_tessellator.sv]
// ---------------------------------------------------------------------------
// Rectangle triangle tessellator
// Turns a filled or stroked rectangle into triangles, with an optional
// affine transform and corner bisector stroke offsets.
// ---------------------------------------------------------------------------
// A rectangle is taken when start is high and busy low. It gives two
// triangles for a fill and eight for a stroke, one beat per cycle on the
// rsp_ ports with rsp_valid high for that single cycle; the receiver cannot
// hold results off. The first triangle passes the input registers, the
// transform, the square root and divider pipelines of the bisector units,
// the outline registers and the emitter. Accepts are spaced by the number
// of triangles the previous one gives, the time the emitter needs to send
// them; busy is high in between. The user must write configuration only
// while no rectangle is in flight; the block itself does not enforce it.
module rectangle_triangle_tessellator #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic signed [31:0] req_rect_left,
   input  logic signed [31:0] req_rect_top,
   input  logic signed [31:0] req_rect_right,
   input  logic signed [31:0] req_rect_bottom,
   input  logic [30:0]        req_stroke_width,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_first_x,
   output logic signed [31:0] rsp_first_y,
   output logic signed [31:0] rsp_second_x,
   output logic signed [31:0] rsp_second_y,
   output logic signed [31:0] rsp_third_x,
   output logic signed [31:0] rsp_third_y,
   output logic               rsp_last_triangle,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int LAT = rtt_pkg::BIS_LAT;

   logic               xf_en_ff;
   logic signed [31:0] cxx_ff, cxy_ff, cyx_ff, cyy_ff, shx_ff, shy_ff;
   logic [2:0]         gap_ff, gap_in;
   logic               accept;
   rtt_pkg::meta_type  m0_ff, m0_in, xf_meta, ol_meta_ff;
   logic signed [31:0] l0_ff, t0_ff, r0_ff, b0_ff;
   rtt_pkg::quad_type  xf_quad, ol_o_ff, ol_i_ff, ol_o_in, ol_i_in;
   rtt_pkg::meta_type  sd_meta_ff [LAT];
   rtt_pkg::quad_type  sd_quad_ff [LAT];
   rtt_pkg::pt_type    bis_off [4];
   rtt_pkg::tri_type   tri_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         xf_en_ff <= 1'b0;
         cxx_ff   <= 32'(64'd1 << COORD_FRAC_BITS);
         cxy_ff   <= '0;
         cyx_ff   <= '0;
         cyy_ff   <= 32'(64'd1 << COORD_FRAC_BITS);
         shx_ff   <= '0;
         shy_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rtt_pkg::CSR_XF_EN:   xf_en_ff <= csr_wdata[0];
            rtt_pkg::CSR_COEF_XX: cxx_ff   <= csr_wdata;
            rtt_pkg::CSR_COEF_XY: cxy_ff   <= csr_wdata;
            rtt_pkg::CSR_COEF_YX: cyx_ff   <= csr_wdata;
            rtt_pkg::CSR_COEF_YY: cyy_ff   <= csr_wdata;
            rtt_pkg::CSR_SHIFT_X: shx_ff   <= csr_wdata;
            rtt_pkg::CSR_SHIFT_Y: shy_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Spacing the accepts by the emitter's beat count keeps the emitter free
   // whenever a rectangle reaches it.
   assign accept = start && !busy;
   assign busy   = (gap_ff != '0);

   always_comb begin
      gap_in = gap_ff;
      if (accept) begin
         gap_in = req_command ? 3'd7 : 3'd1;
      end else if (gap_ff != '0) begin
         gap_in = gap_ff - 3'd1;
      end
   end

   always_comb begin
      m0_in.valid  = accept;
      m0_in.stroke = req_command;
      m0_in.xf_en  = xf_en_ff;
      m0_in.half   = req_stroke_width[30:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
         m0_ff  <= '0;
      end else begin
         gap_ff <= gap_in;
         m0_ff  <= m0_in;
      end
   end

   always_ff @(posedge clock) begin
      l0_ff <= req_rect_left;
      t0_ff <= req_rect_top;
      r0_ff <= req_rect_right;
      b0_ff <= req_rect_bottom;
   end

   rtt_xform #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_xform (
      .clock    (clock),
      .reset    (reset),
      .meta_in  (m0_ff),
      .left     (l0_ff),
      .top      (t0_ff),
      .right    (r0_ff),
      .bottom   (b0_ff),
      .coef_xx  (cxx_ff),
      .coef_xy  (cxy_ff),
      .coef_yx  (cyx_ff),
      .coef_yy  (cyy_ff),
      .shift_x  (shx_ff),
      .shift_y  (shy_ff),
      .meta_out (xf_meta),
      .quad_out (xf_quad)
   );

   rtt_bisect u_bis_tl (
      .clock  (clock),
      .corner (xf_quad[rtt_pkg::CRN_TL]),
      .side_a (xf_quad[rtt_pkg::CRN_BL]),
      .side_b (xf_quad[rtt_pkg::CRN_TR]),
      .half   (xf_meta.half),
      .offset (bis_off[0])
   );

   rtt_bisect u_bis_tr (
      .clock  (clock),
      .corner (xf_quad[rtt_pkg::CRN_TR]),
      .side_a (xf_quad[rtt_pkg::CRN_BR]),
      .side_b (xf_quad[rtt_pkg::CRN_TL]),
      .half   (xf_meta.half),
      .offset (bis_off[1])
   );

   rtt_bisect u_bis_bl (
      .clock  (clock),
      .corner (xf_quad[rtt_pkg::CRN_BL]),
      .side_a (xf_quad[rtt_pkg::CRN_TL]),
      .side_b (xf_quad[rtt_pkg::CRN_BR]),
      .half   (xf_meta.half),
      .offset (bis_off[2])
   );

   rtt_bisect u_bis_br (
      .clock  (clock),
      .corner (xf_quad[rtt_pkg::CRN_BR]),
      .side_a (xf_quad[rtt_pkg::CRN_TR]),
      .side_b (xf_quad[rtt_pkg::CRN_BL]),
      .half   (xf_meta.half),
      .offset (bis_off[3])
   );

   // The corners and control travel alongside the bisector units.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            sd_meta_ff[i] <= '0;
         end
      end else begin
         sd_meta_ff[0] <= xf_meta;
         for (int i = 1; i < LAT; i++) begin
            sd_meta_ff[i] <= sd_meta_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      sd_quad_ff[0] <= xf_quad;
      for (int i = 1; i < LAT; i++) begin
         sd_quad_ff[i] <= sd_quad_ff[i-1];
      end
   end

   // Inner is the corner minus its offset, outer the corner plus it for
   // a stroke. With no transform the offset is half the width, outwards.
   always_comb begin
      rtt_pkg::pt_type    p, off;
      logic signed [31:0] hs;
      hs = $signed({2'b00, sd_meta_ff[LAT-1].half});
      for (int k = 0; k < 4; k++) begin
         p = sd_quad_ff[LAT-1][k];
         if (sd_meta_ff[LAT-1].xf_en) begin
            off = bis_off[k];
         end else begin
            off.x = (k[0] == 1'b0) ? -hs : hs;
            off.y = (k < 2) ? -hs : hs;
         end
         if (sd_meta_ff[LAT-1].stroke) begin
            ol_o_in[k].x = rtt_pkg::sat32(66'(p.x) + 66'(off.x));
            ol_o_in[k].y = rtt_pkg::sat32(66'(p.y) + 66'(off.y));
         end else begin
            ol_o_in[k] = p;
         end
         ol_i_in[k].x = rtt_pkg::sat32(66'(p.x) - 66'(off.x));
         ol_i_in[k].y = rtt_pkg::sat32(66'(p.y) - 66'(off.y));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ol_meta_ff <= '0;
      end else begin
         ol_meta_ff <= sd_meta_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      ol_o_ff <= ol_o_in;
      ol_i_ff <= ol_i_in;
   end

   rtt_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .meta_in   (ol_meta_ff),
      .outer     (ol_o_ff),
      .inner     (ol_i_ff),
      .tri_valid (rsp_valid),
      .tri_out   (tri_out)
   );

   assign rsp_first_x       = tri_out.a.x;
   assign rsp_first_y       = tri_out.a.y;
   assign rsp_second_x      = tri_out.b.x;
   assign rsp_second_y      = tri_out.b.y;
   assign rsp_third_x       = tri_out.c.x;
   assign rsp_third_y       = tri_out.c.y;
   assign rsp_last_triangle = tri_out.last;

endmodule

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// Rectangle tessellator testbench
// Sends filled and stroked rectangles under several transform settings,
// works out every expected triangle in a local predictor and compares each
// triangle beat with the oldest expected one, field by field.
// ---------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  FRAC        = 16;
   localparam int  CYCLE_LIMIT = 300000;
   localparam logic CMD_FILL   = 1'b0;
   localparam logic CMD_STROKE = 1'b1;

   typedef struct {
      rtt_pkg::pt_type a;
      rtt_pkg::pt_type b;
      rtt_pkg::pt_type c;
      logic            last;
   } tri_rec_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_command = 1'b0;
   logic signed [31:0] req_rect_left = '0;
   logic signed [31:0] req_rect_top = '0;
   logic signed [31:0] req_rect_right = '0;
   logic signed [31:0] req_rect_bottom = '0;
   logic [30:0]        req_stroke_width = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_first_x, rsp_first_y, rsp_second_x, rsp_second_y;
   logic signed [31:0] rsp_third_x, rsp_third_y;
   logic               rsp_last_triangle;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   // Local copy of the configuration registers.
   logic               xf_on;
   logic signed [31:0] m_xx, m_xy, m_yx, m_yy, m_sx, m_sy;

   tri_rec_type triangle_q[$];
   int          error_count = 0;
   int          cycle_count = 0;

   rectangle_triangle_tessellator dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d triangles outstanding", triangle_q.size());
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= r + bitv) begin
            n = n - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // Offset of length half along the direction of (vx, vy), rounded per axis.
   function automatic void bisect(input longint vx, input longint vy, input longint half,
                                  output longint ox, output longint oy);
      logic [63:0] ax, ay, mx, len, h, qx, qy;
      ax = (vx < 0) ? -vx : vx;
      ay = (vy < 0) ? -vy : vy;
      mx = (ax > ay) ? ax : ay;
      h  = half;
      ox = 0;
      oy = 0;
      if (mx == 0) return;
      while (mx >= (64'd1 << 31)) begin
         ax = ax >> 1; ay = ay >> 1; mx = mx >> 1;
      end
      while (mx < (64'd1 << 30)) begin
         ax = ax << 1; ay = ay << 1; mx = mx << 1;
      end
      len = int_sqrt(ax * ax + ay * ay);
      qx = (2 * ax * h + len) / (2 * len);
      qy = (2 * ay * h + len) / (2 * len);
      ox = (vx < 0) ? -longint'(qx) : longint'(qx);
      oy = (vy < 0) ? -longint'(qy) : longint'(qy);
   endfunction

   function automatic rtt_pkg::pt_type mk_pt(longint x, longint y);
      rtt_pkg::pt_type p;
      p.x = 32'(clamp32(x));
      p.y = 32'(clamp32(y));
      return p;
   endfunction

   function automatic void push_tri(rtt_pkg::pt_type a, rtt_pkg::pt_type b,
                                    rtt_pkg::pt_type c, logic last);
      tri_rec_type t;
      t.a = a; t.b = b; t.c = c; t.last = last;
      triangle_q.push_back(t);
   endfunction

   function automatic void predict_triangles(logic cmd, longint l, longint t, longint r,
                                             longint b, longint half);
      // Corners in the order top left, top right, bottom left, bottom right.
      longint          cx[4], cy[4], ox, oy, vx, vy;
      longint          xs[4], ys[4];
      int              na[4], nb[4], sx[4], sy[4];
      rtt_pkg::pt_type c[4], outer[4], inner[4];
      xs = '{l, r, l, r};
      ys = '{t, t, b, b};
      na = '{rtt_pkg::CRN_BL, rtt_pkg::CRN_BR, rtt_pkg::CRN_TL, rtt_pkg::CRN_TR};
      nb = '{rtt_pkg::CRN_TR, rtt_pkg::CRN_TL, rtt_pkg::CRN_BR, rtt_pkg::CRN_BL};
      sx = '{-1, 1, -1, 1};
      sy = '{-1, -1, 1, 1};
      for (int i = 0; i < 4; i++) begin
         if (xf_on) begin
            cx[i] = clamp32(fx_mul(m_xx, xs[i]) + fx_mul(m_yx, ys[i]) + m_sx);
            cy[i] = clamp32(fx_mul(m_xy, xs[i]) + fx_mul(m_yy, ys[i]) + m_sy);
         end else begin
            cx[i] = xs[i];
            cy[i] = ys[i];
         end
         c[i] = mk_pt(cx[i], cy[i]);
      end
      if (cmd == CMD_FILL) begin
         push_tri(c[rtt_pkg::CRN_TL], c[rtt_pkg::CRN_TR], c[rtt_pkg::CRN_BL], 1'b0);
         push_tri(c[rtt_pkg::CRN_BL], c[rtt_pkg::CRN_TR], c[rtt_pkg::CRN_BR], 1'b1);
         return;
      end
      for (int i = 0; i < 4; i++) begin
         if (xf_on) begin
            vx = (cx[i] - cx[na[i]]) + (cx[i] - cx[nb[i]]);
            vy = (cy[i] - cy[na[i]]) + (cy[i] - cy[nb[i]]);
            bisect(vx, vy, half, ox, oy);
         end else begin
            ox = sx[i] * half;
            oy = sy[i] * half;
         end
         outer[i] = mk_pt(cx[i] + ox, cy[i] + oy);
         inner[i] = mk_pt(cx[i] - ox, cy[i] - oy);
      end
      push_tri(outer[rtt_pkg::CRN_TL], outer[rtt_pkg::CRN_TR], inner[rtt_pkg::CRN_TL], 1'b0);
      push_tri(inner[rtt_pkg::CRN_TL], outer[rtt_pkg::CRN_TR], inner[rtt_pkg::CRN_TR], 1'b0);
      push_tri(outer[rtt_pkg::CRN_TR], outer[rtt_pkg::CRN_BR], inner[rtt_pkg::CRN_TR], 1'b0);
      push_tri(inner[rtt_pkg::CRN_TR], outer[rtt_pkg::CRN_BR], inner[rtt_pkg::CRN_BR], 1'b0);
      push_tri(outer[rtt_pkg::CRN_BR], outer[rtt_pkg::CRN_BL], inner[rtt_pkg::CRN_BR], 1'b0);
      push_tri(inner[rtt_pkg::CRN_BR], outer[rtt_pkg::CRN_BL], inner[rtt_pkg::CRN_BL], 1'b0);
      push_tri(outer[rtt_pkg::CRN_BL], outer[rtt_pkg::CRN_TL], inner[rtt_pkg::CRN_BL], 1'b0);
      push_tri(inner[rtt_pkg::CRN_BL], outer[rtt_pkg::CRN_TL], inner[rtt_pkg::CRN_TL], 1'b1);
   endfunction

   // ---------------- checking ----------------

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      tri_rec_type e;
      if (!reset && rsp_valid) begin
         if (triangle_q.size() == 0) begin
            report_mismatch("unexpected triangle beat", 1, 0);
         end else begin
            e = triangle_q.pop_front();
            if (rsp_first_x !== e.a.x) report_mismatch("first_x", rsp_first_x, e.a.x);
            if (rsp_first_y !== e.a.y) report_mismatch("first_y", rsp_first_y, e.a.y);
            if (rsp_second_x !== e.b.x) report_mismatch("second_x", rsp_second_x, e.b.x);
            if (rsp_second_y !== e.b.y) report_mismatch("second_y", rsp_second_y, e.b.y);
            if (rsp_third_x !== e.c.x) report_mismatch("third_x", rsp_third_x, e.c.x);
            if (rsp_third_y !== e.c.y) report_mismatch("third_y", rsp_third_y, e.c.y);
            if (rsp_last_triangle !== e.last)
               report_mismatch("last_triangle", rsp_last_triangle, e.last);
         end
      end
   end

   // ---------------- stimulus ----------------

   task automatic send_rect(logic cmd, logic signed [31:0] l, logic signed [31:0] t,
                            logic signed [31:0] r, logic signed [31:0] b, logic [30:0] w,
                            int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_command      <= cmd;
      req_rect_left    <= l;
      req_rect_top     <= t;
      req_rect_right   <= r;
      req_rect_bottom  <= b;
      req_stroke_width <= w;
      do @(posedge clock); while (busy);
      predict_triangles(cmd, l, t, r, b, longint'(w >> 1));
   endtask

   // Lower start and wait for every outstanding triangle.
   task automatic drain();
      start <= 1'b0;
      while (triangle_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         rtt_pkg::CSR_XF_EN:   xf_on = val[0];
         rtt_pkg::CSR_COEF_XX: m_xx = val;
         rtt_pkg::CSR_COEF_XY: m_xy = val;
         rtt_pkg::CSR_COEF_YX: m_yx = val;
         rtt_pkg::CSR_COEF_YY: m_yy = val;
         rtt_pkg::CSR_SHIFT_X: m_sx = val;
         rtt_pkg::CSR_SHIFT_Y: m_sy = val;
         default: ;
      endcase
   endtask

   task automatic set_matrix(logic en, int xx, int xy, int yx, int yy, int tx, int ty);
      drain();
      csr_write(rtt_pkg::CSR_XF_EN, 32'(en));
      csr_write(rtt_pkg::CSR_COEF_XX, xx);
      csr_write(rtt_pkg::CSR_COEF_XY, xy);
      csr_write(rtt_pkg::CSR_COEF_YX, yx);
      csr_write(rtt_pkg::CSR_COEF_YY, yy);
      csr_write(rtt_pkg::CSR_SHIFT_X, tx);
      csr_write(rtt_pkg::CSR_SHIFT_Y, ty);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
   endfunction

   function automatic logic [30:0] rand_width();
      case ($urandom_range(0, 3))
         0: return 31'($urandom);
         1: return 31'($urandom_range(0, 3));
         default: return 31'($urandom_range(0, 32'h0008_0000));
      endcase
   endfunction

   function automatic int rand_coef();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
   endfunction

   // Long runs without gaps alternate with runs of random gaps.
   task automatic random_rects(int count);
      bit burst;
      for (int i = 0; i < count; i++) begin
         if (i % 16 == 0) burst = $urandom_range(0, 2) == 0;
         send_rect($urandom_range(0, 2) != 0, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_width(), burst ? 0 : $urandom_range(0, 6));
      end
   endtask

   task automatic test_directed();
      int unsigned mx, mn;
      mx = 32'h7fffffff;
      mn = 32'h80000000;
      send_rect(CMD_FILL, 0, 0, 32'h10000, 32'h10000, 0, 0);
      send_rect(CMD_FILL, mn, mn, mx, mx, 31'h7fffffff, 0);
      send_rect(CMD_STROKE, 32'h10000, 32'h20000, 32'h50000, 32'h60000, 32'h8000, 0);
      send_rect(CMD_STROKE, mn, mn, mx, mx, 31'h7fffffff, 1);
      send_rect(CMD_STROKE, mx, mx, mn, mn, 31'h7fffffff, 0);
      send_rect(CMD_STROKE, 100, 100, 100, 100, 0, 2);
      send_rect(CMD_STROKE, -5, 7, 9, -3, 1, 0);
      send_rect(CMD_STROKE, 32'hfff00000, 32'h7ff00000, 32'h00100000, 32'h7fffffff,
                31'h00400000, 3);
      set_matrix(1'b1, 32'h10000, 0, 0, 32'h10000, 0, 0);
      send_rect(CMD_STROKE, 32'h10000, 32'h20000, 32'h50000, 32'h60000, 32'h8000, 0);
      // Collapsed rectangle: every bisector is zero.
      send_rect(CMD_STROKE, 32'h30000, 32'h30000, 32'h30000, 32'h30000, 32'h40000, 0);
      send_rect(CMD_STROKE, mn, mn, mx, mx, 31'h7fffffff, 0);
      send_rect(CMD_FILL, mn, mx, mx, mn, 5, 0);
      send_rect(CMD_STROKE, 0, 0, 1, 0, 31'h7fffffff, 1);
      send_rect(CMD_STROKE, -1, -1, 1, 1, 3, 0);
   endtask

   task automatic test_plain_random();
      set_matrix(1'b0, 32'h10000, 0, 0, 32'h10000, 0, 0);
      random_rects(110);
   endtask

   task automatic test_identity_random();
      set_matrix(1'b1, 32'h10000, 0, 0, 32'h10000, 0, 0);
      random_rects(60);
   endtask

   task automatic test_random_matrices();
      for (int p = 0; p < 4; p++) begin
         set_matrix(1'b1, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                    rand_coord(), rand_coord());
         random_rects(45);
      end
   endtask

   task automatic test_extreme_matrices();
      set_matrix(1'b1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h80000000);
      random_rects(25);
      set_matrix(1'b1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff);
      random_rects(25);
      // Rotation by ninety degrees with a shift.
      set_matrix(1'b1, 0, 32'h10000, 32'hffff0000, 0, 32'h123456, 32'hfedcba98);
      random_rects(25);
      set_matrix(1'b1, 0, 0, 0, 0, 0, 0);
      random_rects(10);
   endtask

   initial begin
      xf_on = 1'b0;
      m_xx = 32'h10000; m_xy = 0; m_yx = 0; m_yy = 32'h10000; m_sx = 0; m_sy = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_plain_random();
      test_identity_random();
      test_random_matrices();
      test_extreme_matrices();
      drain();
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/rtt_pkg.sv
hw/rtl/rtt_xform.sv
hw/rtl/rtt_bisect.sv
hw/rtl/rtt_emit.sv
hw/rtl/rectangle_triangle_tessellator.sv
bench/tb_top.sv
